>>> src/scm_pkg.sv
// shared types and constants of the stereo channel mixer
`timescale 1ns / 1ps

package scm_pkg;

  // sample and gain widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 8;

  // volume scale; full scale is a power of two, so the divide is a shift
  localparam int MAX_VOLUME = 128;
  localparam int VOL_SHIFT  = $clog2(MAX_VOLUME);

  // pan gain that means unity
  localparam int PAN_UNITY  = 255;

  // effective channel volume: up to 255 * 255 / MAX_VOLUME
  localparam int VOL_W      = $clog2((PAN_UNITY * PAN_UNITY) / MAX_VOLUME + 1);

  // sample times gain, signed
  localparam int SP_W       = SAMPLE_W + GAIN_W;
  // full product sample * gain * volume, signed
  localparam int PROD_W     = SP_W + VOL_W + 1;
  // magnitude after the volume shift
  localparam int MAG_W      = PROD_W - 2 - VOL_SHIFT;

  // divide by PAN_UNITY through a reciprocal: 2^32 / 255 rounded down
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_SHIFT-1:0] RECIP_M = 32'h0101_0101;
  localparam int RPROD_W    = MAG_W + RECIP_SHIFT;
  localparam int QUO_W      = MAG_W - GAIN_W + 1;

  // accumulate width before saturation
  localparam int SUM_W      = QUO_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(32768);

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_RECIP,
    S_SUM
  } scm_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic acc_we;
    logic emit;
  } scm_cmd_t;

endpackage

>>> src/scm_in_if.sv
// input request channel of the stereo channel mixer
`timescale 1ns / 1ps

interface scm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        start_frame;
  logic        last_of_frame;
  logic [15:0] sample_left;
  logic [15:0] sample_right;
  logic [7:0]  channel_volume;
  logic [7:0]  sound_volume;
  logic [7:0]  left_pan;
  logic [7:0]  right_pan;

  modport source (
    output valid, req_type, start_frame, last_of_frame, sample_left, sample_right,
           channel_volume, sound_volume, left_pan, right_pan,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_frame, last_of_frame, sample_left, sample_right,
           channel_volume, sound_volume, left_pan, right_pan,
    output ready
  );
endinterface

>>> src/scm_out_if.sv
// result channel of the stereo channel mixer
`timescale 1ns / 1ps

interface scm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mix_left;
  logic [15:0] mix_right;

  modport source (output valid, mix_left, mix_right, input ready);
  modport sink (input valid, mix_left, mix_right, output ready);
endinterface

>>> src/scm_cfg_if.sv
// configuration write channel of the stereo channel mixer
`timescale 1ns / 1ps

interface scm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] music_volume;

  modport source (output valid, music_volume, input ready);
  modport sink (input valid, music_volume, output ready);
endinterface

>>> src/scm_lane.sv
// one side of the mix datapath: scale, divide, accumulate, saturate
`timescale 1ns / 1ps

module scm_lane import scm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scm_cmd_t                   cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [GAIN_W-1:0]   gain,
  input  logic        [VOL_W-1:0]    vol_r,
  input  logic                       clr_r,
  output logic signed [SAMPLE_W-1:0] mix
);

  logic signed [SP_W-1:0]     sp_r, sp_nxt;
  logic signed [PROD_W-1:0]   prod;
  logic        [PROD_W-1:0]   mag;
  logic        [MAG_W-1:0]    n_r, n_nxt;
  logic                       neg_r, neg_nxt;
  logic        [RPROD_W-1:0]  rprod;
  logic        [QUO_W-1:0]    q_r, q_nxt;
  logic        [MAG_W-1:0]    q_ext;
  logic        [MAG_W-1:0]    rem;
  logic        [QUO_W-1:0]    q_fix;
  logic signed [SUM_W-1:0]    term;
  logic signed [SUM_W-1:0]    base;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0] mix_r;

  // sample times pan or music gain
  assign sp_nxt = SP_W'(sample) * $signed({1'b0, gain});

  // times volume, then magnitude over full volume scale
  always_comb begin
    prod    = sp_r * $signed({1'b0, vol_r});
    neg_nxt = prod[PROD_W-1];
    mag     = neg_nxt ? PROD_W'(-prod) : PROD_W'(prod);
    n_nxt   = mag[VOL_SHIFT +: MAG_W];
  end

  // reciprocal estimate of n / 255, at most one low
  always_comb begin
    rprod = RPROD_W'(n_r) * RPROD_W'(RECIP_M);
    q_nxt = rprod[RECIP_SHIFT +: QUO_W];
  end

  // correct the estimate, restore sign, accumulate and saturate
  always_comb begin
    q_ext = MAG_W'(q_r);
    rem   = n_r - ((q_ext << GAIN_W) - q_ext);
    q_fix = q_r + QUO_W'(rem >= MAG_W'(PAN_UNITY));
    term  = neg_r ? -$signed({2'b00, q_fix}) : $signed({2'b00, q_fix});
    base  = clr_r ? '0 : {{(SUM_W-SAMPLE_W){acc_r[SAMPLE_W-1]}}, acc_r};
    sum   = base + term;
    if (sum > SUM_MAX) begin
      acc_nxt = SAMPLE_W'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      acc_nxt = SAMPLE_W'(SUM_MIN);
    end else begin
      acc_nxt = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sp_r <= sp_nxt;
    end
    n_r   <= n_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    if (cmd.emit) begin
      mix_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_we) begin
      acc_r <= acc_nxt;
    end
  end

  assign mix = mix_r;

endmodule

>>> src/scm_datapath.sv
// mixer datapath: music gain register, volume, two lanes
`timescale 1ns / 1ps

module scm_datapath import scm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scm_cmd_t                   cmd,
  input  logic                       cfg_we,
  input  logic        [GAIN_W-1:0]   cfg_music_volume,
  input  logic                       req_type,
  input  logic                       start_frame,
  input  logic signed [SAMPLE_W-1:0] sample_left,
  input  logic signed [SAMPLE_W-1:0] sample_right,
  input  logic        [GAIN_W-1:0]   channel_volume,
  input  logic        [GAIN_W-1:0]   sound_volume,
  input  logic        [GAIN_W-1:0]   left_pan,
  input  logic        [GAIN_W-1:0]   right_pan,
  output logic signed [SAMPLE_W-1:0] mix_left,
  output logic signed [SAMPLE_W-1:0] mix_right
);

  logic [GAIN_W-1:0]     music_vol_r;
  logic [GAIN_W-1:0]     eff_vol;
  logic [2*GAIN_W-1:0]   vol_prod;
  logic [VOL_W-1:0]      vol_r, vol_nxt;
  logic                  clr_r, clr_nxt;
  logic [GAIN_W-1:0]     gain_left, gain_right;

  // music runs through the channel path at unity volume with its gain as pan
  always_comb begin
    eff_vol    = (sound_volume == '0) ? GAIN_W'(MAX_VOLUME) : sound_volume;
    vol_prod   = channel_volume * eff_vol;
    vol_nxt    = req_type ? VOL_W'(vol_prod >> VOL_SHIFT) : VOL_W'(PAN_UNITY);
    gain_left  = req_type ? left_pan  : music_vol_r;
    gain_right = req_type ? right_pan : music_vol_r;
    clr_nxt    = !req_type || start_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      music_vol_r <= GAIN_W'(MAX_VOLUME);
    end else if (cfg_we) begin
      music_vol_r <= cfg_music_volume;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vol_r <= vol_nxt;
      clr_r <= clr_nxt;
    end
  end

  scm_lane u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sample (sample_left),
    .gain   (gain_left),
    .vol_r  (vol_r),
    .clr_r  (clr_r),
    .mix    (mix_left)
  );

  scm_lane u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sample (sample_right),
    .gain   (gain_right),
    .vol_r  (vol_r),
    .clr_r  (clr_r),
    .mix    (mix_right)
  );

endmodule

>>> src/scm_ctrl.sv
// mixer controller: step sequencing and output slot
`timescale 1ns / 1ps

module scm_ctrl import scm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output scm_cmd_t cmd
);

  scm_state_t state_r, state_nxt;
  logic       last_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_SUM;
      S_SUM:   if (!last_r || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SUM: begin
        cmd.acc_we = !last_r || out_free;
        cmd.emit   = last_r && out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        last_r <= in_last;
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCALE))
    else $error("accepted request did not start the scale step");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken result");

  a_no_last_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && !last_r) |-> (cmd.acc_we && !cmd.emit))
    else $error("request without frame end stalled or emitted");

  a_valid_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SUM && last_r))
    else $error("result appeared outside the sum step of a frame end");
`endif

endmodule

>>> src/stereo_channel_mixer.sv
// top level of the stereo channel mixer
`timescale 1ns / 1ps

// channel  | dir | handshake    | payload
// in_ch    | in  | valid/ready  | req_type, start_frame, last_of_frame, samples, volumes, pans
// out_ch   | out | valid/ready  | mix_left, mix_right (saturated 16-bit)
// cfg_ch   | in  | valid/ready  | music_volume, always ready
//
// each request runs through the steps: accept with gain and volume products, full product
// and shift, reciprocal multiply for the divide by 255, correct/accumulate/saturate
// the fourth step stalls only on a frame end while the output slot is still full
// synchronous active-low reset clears accumulator and controller, sets music_volume to 128
// a waiting result does not block the next request; the output register holds it

module stereo_channel_mixer import scm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  scm_in_if.sink  in_ch,
  scm_out_if.source out_ch,
  scm_cfg_if.sink cfg_ch
);

  scm_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;
  logic signed [SAMPLE_W-1:0] mix_left, mix_right;

  // user makes config writes only while idle; block does not enforce it; port always ready
  assign cfg_ch.ready = 1'b1;

  scm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_of_frame),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // music and channel requests share both lanes; music is a channel at unity
  // volume whose pan gain is music_volume, starting from zero
  scm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_ch.valid),
    .cfg_music_volume (cfg_ch.music_volume),
    .req_type         (in_ch.req_type),
    .start_frame      (in_ch.start_frame),
    .sample_left      ($signed(in_ch.sample_left)),
    .sample_right     ($signed(in_ch.sample_right)),
    .channel_volume   (in_ch.channel_volume),
    .sound_volume     (in_ch.sound_volume),
    .left_pan         (in_ch.left_pan),
    .right_pan        (in_ch.right_pan),
    .mix_left         (mix_left),
    .mix_right        (mix_right)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.mix_left  = mix_left;
  assign out_ch.mix_right = mix_right;

endmodule

>>> verif/scm_mix_checker.sv
// request codes and the self-checking scoreboard of the stereo channel mixer
`timescale 1ns / 1ps

package scm_tb_pkg;
  localparam logic REQ_MUSIC   = 1'b0;
  localparam logic REQ_CHANNEL = 1'b1;
endpackage

module scm_mix_checker import scm_pkg::*, scm_tb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  scm_in_if    in_mon,
  scm_out_if   out_mon,
  scm_cfg_if   cfg_mon,
  output int   mismatch_count,
  output int   frames_owed
);

  localparam longint MIX_MAX = 32767;
  localparam longint MIX_MIN = -32768;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
  } mix_frame_t;

  mix_frame_t         pending_frames[$];
  logic [7:0]         music_gain;
  logic signed [15:0] acc_l;
  logic signed [15:0] acc_r;

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > MIX_MAX) return 16'(MIX_MAX);
    if (v < MIX_MIN) return 16'(MIX_MIN);
    return 16'(v);
  endfunction

  // apply one accepted request to the accumulator, queue a frame on frame end
  task automatic mix_source();
    longint     sl;
    longint     sr;
    longint     eff;
    longint     vol;
    longint     base_l;
    longint     base_r;
    mix_frame_t frame;
    sl = longint'($signed(in_mon.sample_left));
    sr = longint'($signed(in_mon.sample_right));
    if (in_mon.req_type == REQ_MUSIC) begin
      acc_l = clip16(sl * longint'(music_gain) / MAX_VOLUME);
      acc_r = clip16(sr * longint'(music_gain) / MAX_VOLUME);
    end else begin
      if (in_mon.sound_volume == 8'd0) eff = longint'(MAX_VOLUME);
      else eff = longint'(in_mon.sound_volume);
      vol = longint'(in_mon.channel_volume) * eff / MAX_VOLUME;
      if (in_mon.start_frame) begin
        base_l = 0;
        base_r = 0;
      end else begin
        base_l = longint'(acc_l);
        base_r = longint'(acc_r);
      end
      acc_l = clip16(base_l + sl * longint'(in_mon.left_pan) * vol / (PAN_UNITY * MAX_VOLUME));
      acc_r = clip16(base_r + sr * longint'(in_mon.right_pan) * vol / (PAN_UNITY * MAX_VOLUME));
    end
    if (in_mon.last_of_frame) begin
      frame.left  = acc_l;
      frame.right = acc_r;
      pending_frames.push_back(frame);
    end
  endtask

  task automatic check_frame();
    mix_frame_t want;
    if (pending_frames.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected frame, expected none, actual L=%0d R=%0d", $time,
               $signed(out_mon.mix_left), $signed(out_mon.mix_right));
    end else begin
      want = pending_frames.pop_front();
      if (want.left !== out_mon.mix_left || want.right !== out_mon.mix_right) begin
        mismatch_count++;
        $display("%0t: frame mismatch, expected L=%0d R=%0d, actual L=%0d R=%0d", $time,
                 $signed(want.left), $signed(want.right),
                 $signed(out_mon.mix_left), $signed(out_mon.mix_right));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      music_gain = 8'(MAX_VOLUME);
      acc_l      = '0;
      acc_r      = '0;
      pending_frames.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_frame();
      if (cfg_mon.valid && cfg_mon.ready) music_gain = cfg_mon.music_volume;
      if (in_mon.valid && in_mon.ready) mix_source();
    end
    frames_owed = pending_frames.size();
  end

endmodule

>>> verif/testbench.sv
// stimulus, idling control and verdict for the stereo channel mixer
`timescale 1ns / 1ps

module testbench;
  import scm_tb_pkg::*;

  // drain pause after the last frame: a request without frame end may still be in flight
  localparam int DRAIN_CYCLES   = 8;
  // long output hold-off so the block fills up and stalls its input
  localparam int HOLD_CYCLES    = 400;
  // cycles with no handshake on any channel before giving up
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 250;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic        req_type;
    logic        start_frame;
    logic        last_of_frame;
    logic [15:0] sample_left;
    logic [15:0] sample_right;
    logic [7:0]  channel_volume;
    logic [7:0]  sound_volume;
    logic [7:0]  left_pan;
    logic [7:0]  right_pan;
  } mix_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // idling knobs, in percent of cycles
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  // receiver hold-off handshake between stimulus and the hold-off process
  logic hold_go     = 1'b0;
  logic hold_active = 1'b0;

  int   mismatch_count;
  int   frames_owed;

  scm_in_if  in_ch ();
  scm_out_if out_ch ();
  scm_cfg_if cfg_ch ();

  stereo_channel_mixer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  scm_mix_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (mismatch_count),
    .frames_owed    (frames_owed)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, forced low during the hold-off
  always @(posedge clk) begin
    if (hold_active) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold-off counted here so the sender keeps offering requests meanwhile
  initial begin : recv_holdoff
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // watchdog: ends the run when no channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // request builders for the directed part
  function automatic mix_req_t music_req(input logic [15:0] sl, input logic [15:0] sr,
                                         input logic last);
    mix_req_t r;
    r.req_type       = REQ_MUSIC;
    r.start_frame    = 1'b0;
    r.last_of_frame  = last;
    r.sample_left    = sl;
    r.sample_right   = sr;
    r.channel_volume = 8'd0;
    r.sound_volume   = 8'd0;
    r.left_pan       = 8'd0;
    r.right_pan      = 8'd0;
    return r;
  endfunction

  function automatic mix_req_t channel_req(input logic start, input logic last,
                                           input logic [15:0] sl, input logic [15:0] sr,
                                           input logic [7:0] cvol, input logic [7:0] svol,
                                           input logic [7:0] pl, input logic [7:0] pr);
    mix_req_t r;
    r.req_type       = REQ_CHANNEL;
    r.start_frame    = start;
    r.last_of_frame  = last;
    r.sample_left    = sl;
    r.sample_right   = sr;
    r.channel_volume = cvol;
    r.sound_volume   = svol;
    r.left_pan       = pl;
    r.right_pan      = pr;
    return r;
  endfunction

  // samples lean on the extremes now and then
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(11))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // volumes mostly in range, sometimes beyond max volume
  function automatic logic [7:0] rand_volume();
    if ($urandom_range(99) < 80) return 8'($urandom_range(0, 128));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_pan();
    case ($urandom_range(7))
      0: return 8'd255;
      1: return 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic mix_req_t rand_req();
    mix_req_t r;
    r.req_type       = 1'($urandom);
    r.start_frame    = 1'($urandom);
    r.last_of_frame  = 1'($urandom);
    r.sample_left    = rand_sample();
    r.sample_right   = rand_sample();
    r.channel_volume = rand_volume();
    r.sound_volume   = rand_volume();
    r.left_pan       = rand_pan();
    r.right_pan      = rand_pan();
    return r;
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_mix_req(input mix_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= r.req_type;
    in_ch.start_frame    <= r.start_frame;
    in_ch.last_of_frame  <= r.last_of_frame;
    in_ch.sample_left    <= r.sample_left;
    in_ch.sample_right   <= r.sample_right;
    in_ch.channel_volume <= r.channel_volume;
    in_ch.sound_volume   <= r.sound_volume;
    in_ch.left_pan       <= r.left_pan;
    in_ch.right_pan      <= r.right_pan;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering, wait for every owed frame, then let the pipeline empty
  task automatic wait_mix_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (frames_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_music_volume(input logic [7:0] v);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.music_volume <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct   = 51;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct   = 0;
        recv_stall_pct <= 51;
      end
      default: begin
        send_idle_pct   = 19;
        recv_stall_pct <= 19;
      end
    endcase
  endtask

  // mostly well-formed frames: optional music, then channels, frame end on the last;
  // the rest is noise with random flags
  task automatic run_random_frames(input int n_items);
    int       sent;
    int       n_ch;
    bit       with_music;
    mix_req_t r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_mix_req(rand_req());
        sent++;
      end else begin
        n_ch       = $urandom_range(1, 6);
        with_music = ($urandom_range(99) < 70);
        if (with_music) begin
          r               = rand_req();
          r.req_type      = REQ_MUSIC;
          r.last_of_frame = 1'b0;
          send_mix_req(r);
          sent++;
        end
        for (int i = 0; i < n_ch; i++) begin
          r               = rand_req();
          r.req_type      = REQ_CHANNEL;
          r.start_frame   = !with_music && (i == 0);
          r.last_of_frame = (i == n_ch - 1);
          send_mix_req(r);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] phase_vol [8];
    mix_req_t   r;

    // every block input known from time zero
    in_ch.valid          = 1'b0;
    in_ch.req_type       = REQ_MUSIC;
    in_ch.start_frame    = 1'b0;
    in_ch.last_of_frame  = 1'b0;
    in_ch.sample_left    = '0;
    in_ch.sample_right   = '0;
    in_ch.channel_volume = '0;
    in_ch.sound_volume   = '0;
    in_ch.left_pan       = '0;
    in_ch.right_pan      = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.music_volume  = '0;

    phase_vol = '{8'd200, 8'd0, 8'd128, 8'd1, 8'd255, 8'd127,
                  8'($urandom_range(0, 128)), 8'($urandom)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset music volume, no idling
    set_idle_mode(IDLE_NONE);
    send_mix_req(music_req(16'h7fff, 16'h8000, 1'b1));
    // start flag on music has no effect
    r = music_req(16'h1234, 16'hedcc, 1'b0);
    r.start_frame = 1'b1;
    send_mix_req(r);
    // zero sound volume means full volume
    send_mix_req(channel_req(1'b0, 1'b1, 16'd1000, -16'sd1000, 8'd128, 8'd0, 8'd255, 8'd128));
    // channel without start adds on top of the already emitted frame
    send_mix_req(channel_req(1'b0, 1'b1, 16'd100, 16'd100, 8'd64, 8'd64, 8'd255, 8'd255));
    send_mix_req(channel_req(1'b1, 1'b1, 16'h7fff, 16'h8000, 8'd128, 8'd128, 8'd255, 8'd255));
    // saturation at both rails after the add
    send_mix_req(music_req(16'h7fff, 16'h8000, 1'b0));
    send_mix_req(channel_req(1'b0, 1'b1, 16'h7fff, 16'h8000, 8'd128, 8'd0, 8'd255, 8'd255));
    // volumes beyond max volume used as given
    send_mix_req(channel_req(1'b1, 1'b1, 16'h8000, 16'h7fff, 8'd255, 8'd255, 8'd255, 8'd255));
    // wide intermediate only clipped after the accumulate
    send_mix_req(channel_req(1'b1, 1'b0, 16'h7fff, 16'h7fff, 8'd255, 8'd255, 8'd0, 8'd255));
    send_mix_req(channel_req(1'b0, 1'b1, 16'h8000, 16'h8000, 8'd200, 8'd1, 8'd1, 8'd255));
    // tiny volumes and pans: the effective volume truncates to zero
    send_mix_req(channel_req(1'b1, 1'b1, 16'hffff, 16'h0001, 8'd1, 8'd1, 8'd1, 8'd1));
    // zero channel volume and zero pans
    send_mix_req(channel_req(1'b1, 1'b1, 16'h1234, 16'h5678, 8'd0, 8'd0, 8'd0, 8'd0));
    // frame without end, then a closing channel
    send_mix_req(music_req(16'hc000, 16'h4000, 1'b0));
    send_mix_req(channel_req(1'b0, 1'b1, 16'h4000, 16'hc000, 8'd128, 8'd128, 8'd255, 8'd255));
    wait_mix_drained();

    // music gain above unity saturates the scaled sample
    write_music_volume(8'd255);
    send_mix_req(music_req(16'h7fff, 16'h8000, 1'b1));
    send_mix_req(music_req(16'h4000, 16'hffff, 1'b1));
    wait_mix_drained();

    write_music_volume(8'd0);
    send_mix_req(music_req(16'h7fff, 16'h8000, 1'b1));
    send_mix_req(channel_req(1'b0, 1'b1, 16'h0100, 16'hff00, 8'd128, 8'd0, 8'd255, 8'd255));
    wait_mix_drained();

    // random phases, one music volume and one idling pattern each
    for (int p = 0; p < 8; p++) begin
      write_music_volume(phase_vol[p]);
      set_idle_mode(idle_mode_t'(p % 4));
      run_random_frames(PHASE_ITEMS);
      wait_mix_drained();
    end

    // back-pressure: result side held off while frame ends keep coming
    write_music_volume(8'($urandom_range(0, 128)));
    set_idle_mode(IDLE_NONE);
    hold_go <= 1'b1;
    repeat (60) begin
      r = rand_req();
      r.last_of_frame = ($urandom_range(99) < 80);
      send_mix_req(r);
    end
    wait_mix_drained();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/scm_pkg.sv
src/scm_in_if.sv
src/scm_out_if.sv
src/scm_cfg_if.sv
src/scm_lane.sv
src/scm_datapath.sv
src/scm_ctrl.sv
src/stereo_channel_mixer.sv
verif/scm_mix_checker.sv
verif/testbench.sv
